FILE: sv/tgpg_pkg.sv
// Shared types, codes and constants for the text/graphics pixel generator.
package tgpg_pkg;

    typedef enum logic [1:0] {
        ACT_RENDER   = 2'd0,
        ACT_FONT_WR  = 2'd1,
        ACT_CHAR_WR  = 2'd2,
        ACT_RESERVED = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_GRAPHICS_MODE = 2'd0,
        REG_ROM_MID       = 2'd1,
        REG_ROM_HIGH      = 2'd2,
        REG_UNUSED        = 2'd3
    } t_reg_index;

    localparam int CHAR_AW = 11;
    localparam int FONT_AW = 10;
    localparam logic [7:0] CODE_MID_FIRST = 8'd128;
    localparam logic [7:0] CODE_FONT_ONLY = 8'd192;
    localparam logic [7:0] CURSOR_GLYPH   = 8'hff;

    // One column's work as it travels from the front to the back.
    typedef struct packed {
        logic       graphics;
        logic [7:0] pattern;
        logic [3:0] color;
    } t_cmd;

    // Palette entries of the three non-background graphics pixel values.
    function automatic logic [3:0] gfx_palette(input logic [1:0] field);
        logic [3:0] pal;
        case (field)
            2'd1:    pal = 4'd8;
            2'd2:    pal = 4'd6;
            2'd3:    pal = 4'd5;
            default: pal = 4'd0;
        endcase
        return pal;
    endfunction

endpackage

FILE: sv/tgpg_front.sv
// Front end: configuration, glyph store writes and reads, and column classification.
module tgpg_front #(
    parameter int QUEUE_DEPTH = 4,
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [0:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_action,
    input  logic                 i_display_enable,
    input  logic [7:0]           i_screen_code,
    input  logic [3:0]           i_column_color,
    input  logic [2:0]           i_glyph_line,
    input  logic                 i_cursor_here,
    input  logic [10:0]          i_store_address,
    input  logic [7:0]           i_store_data,
    input  logic [CW-1:0]        i_queue_count,
    output logic                 o_push,
    output tgpg_pkg::t_cmd       o_cmd
);

    logic [7:0] r_char_mem [2**tgpg_pkg::CHAR_AW];
    logic [7:0] r_font_mem [2**tgpg_pkg::FONT_AW];

    logic r_graphics_mode;
    logic r_rom_mid;
    logic r_rom_high;

    logic       r_s1_valid;
    logic       r_s1_graphics;
    logic [7:0] r_s1_code;
    logic [3:0] r_s1_color;
    logic       r_s1_cursor;
    logic       r_s1_use_char;
    logic [7:0] r_char_rd;
    logic [7:0] r_font_rd;

    logic                       accept;
    logic                       render;
    logic                       use_char;
    logic [tgpg_pkg::CHAR_AW-1:0] glyph_addr;
    logic [CW:0]                pending;
    logic [7:0]                 text_pattern;

    // Room is reserved for the column still in the read stage.
    assign pending    = {1'b0, i_queue_count} + (CW + 1)'(r_s1_valid);
    assign o_in_ready = pending < (CW + 1)'(QUEUE_DEPTH);
    assign accept     = i_in_valid && o_in_ready;
    assign render     = accept && (i_action == tgpg_pkg::ACT_RENDER) && i_display_enable;
    assign glyph_addr = {i_screen_code, i_glyph_line};

    assign use_char = (i_screen_code < tgpg_pkg::CODE_MID_FIRST)
                   || ((i_screen_code < tgpg_pkg::CODE_FONT_ONLY) && r_rom_mid)
                   || ((i_screen_code > tgpg_pkg::CODE_FONT_ONLY) && r_rom_high);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_graphics_mode <= 1'b1;
            r_rom_mid       <= 1'b1;
            r_rom_high      <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tgpg_pkg::REG_GRAPHICS_MODE: r_graphics_mode <= i_cfg_data[0];
                tgpg_pkg::REG_ROM_MID:       r_rom_mid       <= i_cfg_data[0];
                tgpg_pkg::REG_ROM_HIGH:      r_rom_high      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_action == tgpg_pkg::ACT_CHAR_WR)) begin
            r_char_mem[i_store_address] <= i_store_data;
        end
        if (accept && (i_action == tgpg_pkg::ACT_FONT_WR)) begin
            r_font_mem[i_store_address[tgpg_pkg::FONT_AW-1:0]] <= i_store_data;
        end
        if (render) begin
            r_char_rd <= r_char_mem[glyph_addr];
            r_font_rd <= r_font_mem[glyph_addr[tgpg_pkg::FONT_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= render;
        end
        if (render) begin
            r_s1_graphics <= r_graphics_mode;
            r_s1_code     <= i_screen_code;
            r_s1_color    <= i_column_color;
            r_s1_cursor   <= i_cursor_here;
            r_s1_use_char <= use_char;
        end
    end

    always_comb begin
        if (r_s1_cursor) begin
            text_pattern = tgpg_pkg::CURSOR_GLYPH;
        end else if (r_s1_use_char) begin
            text_pattern = r_char_rd;
        end else begin
            text_pattern = r_font_rd;
        end
    end

    assign o_push           = r_s1_valid;
    assign o_cmd.graphics   = r_s1_graphics;
    assign o_cmd.pattern    = r_s1_graphics ? r_s1_code : text_pattern;
    assign o_cmd.color      = r_s1_color;

endmodule

FILE: sv/tgpg_queue.sv
// Small command queue between the front end and the pixel serializer.
module tgpg_queue #(
    parameter int QUEUE_DEPTH = 4,
    localparam int CW = $clog2(QUEUE_DEPTH + 1),
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tgpg_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_head_valid,
    output tgpg_pkg::t_cmd  o_head,
    output logic [CW-1:0]   o_count
);

    tgpg_pkg::t_cmd r_mem [QUEUE_DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [AW-1:0]  n_wr_ptr;
    logic [AW-1:0]  n_rd_ptr;
    logic [CW-1:0]  n_count;
    logic           do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign o_count      = r_count;

endmodule

FILE: sv/tgpg_back.sv
// Back end: serializes each column command into registered pixels.
module tgpg_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  tgpg_pkg::t_cmd  i_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic            o_is_background,
    output logic [3:0]      o_palette_index,
    output logic            o_last_pixel
);

    logic       r_busy;
    logic       r_graphics;
    logic [7:0] r_pattern;
    logic [3:0] r_color;
    logic [2:0] r_cnt;
    logic       r_out_valid;
    logic       r_bg;
    logic [3:0] r_pal;
    logic       r_last;

    logic       n_busy;
    logic [7:0] n_pattern;
    logic [2:0] n_cnt;
    logic       n_out_valid;
    logic       n_bg;
    logic [3:0] n_pal;
    logic       n_last;

    logic       advance;
    logic       emit;
    logic       src_graphics;
    logic [7:0] src_pattern;
    logic [3:0] src_color;
    logic [2:0] src_cnt;

    assign advance = !r_out_valid || i_out_ready;
    assign emit    = advance && (r_busy || i_head_valid);
    assign o_pop   = advance && !r_busy && i_head_valid;

    // A fresh column starts straight from the queue head, so columns run gap-free.
    assign src_graphics = r_busy ? r_graphics : i_head.graphics;
    assign src_pattern  = r_busy ? r_pattern  : i_head.pattern;
    assign src_color    = r_busy ? r_color    : i_head.color;
    assign src_cnt      = r_busy ? r_cnt      : 3'd0;

    always_comb begin
        n_busy      = r_busy;
        n_pattern   = r_pattern;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_bg        = r_bg;
        n_pal       = r_pal;
        n_last      = r_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_cnt       = src_cnt + 1'b1;
            if (src_graphics) begin
                n_bg      = (src_pattern[7:6] == 2'd0);
                n_pal     = tgpg_pkg::gfx_palette(src_pattern[7:6]);
                n_last    = (src_cnt == 3'd3);
                n_pattern = {src_pattern[5:0], 2'b00};
            end else begin
                n_bg      = !src_pattern[7];
                n_pal     = src_pattern[7] ? src_color : 4'd0;
                n_last    = (src_cnt == 3'd7);
                n_pattern = {src_pattern[6:0], 1'b0};
            end
            n_busy = !n_last;
        end else if (advance) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
        r_pattern <= n_pattern;
        r_cnt     <= n_cnt;
        r_bg      <= n_bg;
        r_pal     <= n_pal;
        r_last    <= n_last;
        if (o_pop) begin
            r_graphics <= i_head.graphics;
            r_color    <= i_head.color;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_is_background = r_bg;
    assign o_palette_index = r_pal;
    assign o_last_pixel    = r_last;

endmodule

FILE: sv/text_graphics_pixel_generator.sv
// Top level of the text/graphics pixel generator.
//
// Input channel (i_in_valid / o_in_ready) carries one column or one glyph store
// write per transaction. A render transaction with display enable set produces
// four pixels in graphics mode or eight pixels in text mode on the output
// channel (o_out_valid / i_out_ready), one pixel per transaction, the final one
// flagged by o_last_pixel. Writes and disabled columns produce nothing.
// The first pixel of a column passes the store read stage, the queue and the
// output register. The pixel serializer gives one pixel per cycle at the
// output while the receiver is ready; writes and disabled columns are taken
// one per cycle while a queue slot is free.
// The glyph stores are single-port block memories with registered reads; each
// entry must be written before a column reads it. A queue of QUEUE_DEPTH column
// commands separates the store read stage from the serializer.
// Reset sets graphics mode and both character store selects, and empties the
// pipeline; store contents are not cleared. When the receiver stalls, the
// current pixel holds, the queue fills, and then o_in_ready drops.
module text_graphics_pixel_generator #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [0:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic        i_display_enable,
    input  logic [7:0]  i_screen_code,
    input  logic [3:0]  i_column_color,
    input  logic [2:0]  i_glyph_line,
    input  logic        i_cursor_here,
    input  logic [10:0] i_store_address,
    input  logic [7:0]  i_store_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_is_background,
    output logic [3:0]  o_palette_index,
    output logic        o_last_pixel
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic           push;
    tgpg_pkg::t_cmd cmd;
    logic           pop;
    logic           head_valid;
    tgpg_pkg::t_cmd head;
    logic [CW-1:0]  queue_count;

    tgpg_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_display_enable (i_display_enable),
        .i_screen_code    (i_screen_code),
        .i_column_color   (i_column_color),
        .i_glyph_line     (i_glyph_line),
        .i_cursor_here    (i_cursor_here),
        .i_store_address  (i_store_address),
        .i_store_data     (i_store_data),
        .i_queue_count    (queue_count),
        .o_push           (push),
        .o_cmd            (cmd)
    );

    tgpg_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (cmd),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head),
        .o_count      (queue_count)
    );

    tgpg_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (head_valid),
        .i_head          (head),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_is_background (o_is_background),
        .o_palette_index (o_palette_index),
        .o_last_pixel    (o_last_pixel)
    );

endmodule

FILE: sv/tgpg_checker.sv
// Port-level checker for the pixel generator, bound to the top level.
module tgpg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_is_background,
    input logic [3:0]  o_palette_index,
    input logic        o_last_pixel
);

    // The output side comes out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A background pixel never carries a palette entry.
    a_bg_palette: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_background |-> o_palette_index == 4'd0)
        else $error("background pixel with nonzero palette index");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_is_background) && $stable(o_palette_index) && $stable(o_last_pixel))
        else $error("output payload changed while stalled");

endmodule

bind text_graphics_pixel_generator tgpg_checker u_tgpg_checker (.*);
